[hdl/wsg_pkg.sv]
// shared constants, types and the sine level table for the waveform sample generator
package wsg_pkg;

   // one period of the waveform, a power of two up to 65536
   localparam int SAMPLES_PER_PERIOD = 256;
   localparam int PHASE_W            = $clog2(SAMPLES_PER_PERIOD);
   localparam int HALF_PERIOD        = SAMPLES_PER_PERIOD / 2;

   // normalized level in q16, 0 .. 1.0 inclusive
   localparam int LEVEL_FRAC_W = 16;
   localparam int LEVEL_W      = LEVEL_FRAC_W + 1;
   localparam int LEVEL_ONE    = 1 << LEVEL_FRAC_W;
   localparam int LEVEL_STEP   = LEVEL_ONE / SAMPLES_PER_PERIOD;

   localparam int CODE_W      = 8;
   localparam int SHAPE_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [SHAPE_W-1:0] shape_type;
   typedef level_type          sine_table_type [SAMPLES_PER_PERIOD];

   // wave shapes
   localparam shape_type SHAPE_SINE     = 2'd0;
   localparam shape_type SHAPE_SQUARE   = 2'd1;
   localparam shape_type SHAPE_TRIANGLE = 2'd2;
   localparam shape_type SHAPE_SAWTOOTH = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_SHAPE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_FLOOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_CEILING = 2'd2;

   // q30 odd polynomial for sin(pi/2 * x)
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] SIN_K1  = 64'd1686629713;
   localparam logic [63:0] SIN_K3  = 64'd693598669;
   localparam logic [63:0] SIN_K5  = 64'd85569306;
   localparam logic [63:0] SIN_K7  = 64'd5026995;
   localparam logic [63:0] SIN_K9  = 64'd172271;

   function automatic logic [63:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] p;
      x2 = (x * x) >> 30;
      p  = SIN_K9;
      p  = SIN_K7 - ((p * x2) >> 30);
      p  = SIN_K5 - ((p * x2) >> 30);
      p  = SIN_K3 - ((p * x2) >> 30);
      p  = SIN_K1 - ((p * x2) >> 30);
      p  = (p * x) >> 30;
      if (p > Q30_ONE) begin
         p = Q30_ONE;
      end
      return p;
   endfunction

   // (sin(2*pi*i/N) + 1) / 2 in q16 for every phase index
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    q;
      logic [63:0]    r;
      logic [63:0]    x;
      logic [63:0]    s;
      logic [63:0]    sum;
      for (int i = 0; i < SAMPLES_PER_PERIOD; i++) begin
         q = 64'(4 * i) / 64'(SAMPLES_PER_PERIOD);
         r = 64'(4 * i) % 64'(SAMPLES_PER_PERIOD);
         if (q[0]) begin
            x = ((64'(SAMPLES_PER_PERIOD) - r) << 30) / 64'(SAMPLES_PER_PERIOD);
         end else begin
            x = (r << 30) / 64'(SAMPLES_PER_PERIOD);
         end
         s = quarter_sine(x);
         if (q[1]) begin
            sum = Q30_ONE - s;
         end else begin
            sum = Q30_ONE + s;
         end
         tbl[i] = LEVEL_W'((sum + 64'd16384) >> 15);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

[hdl/wsg_req_if.sv]
// request channel: one beat per sample, carries the phase advance flag
interface wsg_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

[hdl/wsg_rsp_if.sv]
// response channel: one beat per sample, carries the dac code and range flag
interface wsg_rsp_if import wsg_pkg::*;;
   logic     valid;
   logic     ready;
   code_type dac_code;
   logic     range_error;

   modport source (output valid, output dac_code, output range_error, input ready);
   modport sink   (input valid, input dac_code, input range_error, output ready);
endinterface

[hdl/wsg_level.sv]
// phase index to normalized q16 level for the selected wave shape
module wsg_level import wsg_pkg::*; (
   input  shape_type shape,
   input  phase_type phase,
   output level_type level
);

   level_type phase_l;
   logic      lower_half;

   assign phase_l    = LEVEL_W'(phase);
   assign lower_half = (phase < PHASE_W'(HALF_PERIOD));

   always_comb begin
      case (shape)
         SHAPE_SINE: begin
            level = SINE_TABLE[phase];
         end
         SHAPE_SQUARE: begin
            level = lower_half ? LEVEL_W'(LEVEL_ONE) : '0;
         end
         SHAPE_TRIANGLE: begin
            if (lower_half) begin
               level = LEVEL_W'(phase_l * LEVEL_W'(2 * LEVEL_STEP));
            end else begin
               level = LEVEL_W'((LEVEL_W'(SAMPLES_PER_PERIOD)
                        - ((phase_l - LEVEL_W'(HALF_PERIOD)) << 1))
                        * LEVEL_W'(LEVEL_STEP));
            end
         end
         SHAPE_SAWTOOTH: begin
            level = LEVEL_W'((phase_l + LEVEL_W'(1)) * LEVEL_W'(LEVEL_STEP));
         end
         default: begin
            level = '0;
         end
      endcase
   end

endmodule

[hdl/waveform_sample_generator.sv]
// top level of the waveform sample generator: phase counter, level stage, scaling stage
//
// Every request beat yields one response beat holding the dac code for the
// current phase index of a period of SAMPLES_PER_PERIOD samples; when the
// beat's advance flag is set the index then steps, wrapping at the end of the
// period. The shape (sine, square, triangle, sawtooth) and the floor and
// ceiling codes come from three write-only registers, which should only be
// changed while no beat is in flight. The code is floor plus the q16 level
// times (ceiling - floor), rounded half up; if floor is not below ceiling the
// code is the floor and range_error is set. An accepted request beat goes
// first into the level register, which holds the table and shape lookup,
// then into the output register, which holds the 17x8 multiply and rounding.
// One beat is taken every cycle as long as the response side keeps taking
// beats; a stalled response fills the two stages and then holds off requests.
// Reset is synchronous and restores the registers to sine, floor 0, ceiling
// 255 and the phase index to zero; there is no clearing pass.
module waveform_sample_generator import wsg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   wsg_req_if.sink                req_if,
   wsg_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PROD_W     = LEVEL_W + CODE_W;
   localparam int ROUND_HALF = 1 << (LEVEL_FRAC_W - 1);

   // configuration registers
   shape_type shape_ff;
   code_type  floor_ff;
   code_type  ceiling_ff;

   // phase counter
   phase_type phase_ff;
   phase_type phase_in;

   // level stage
   logic      mid_valid_ff;
   logic      mid_valid_in;
   level_type level_ff;
   level_type level_in;

   // output stage
   logic      out_valid_ff;
   logic      out_valid_in;
   code_type  code_ff;
   code_type  code_in;
   logic      error_ff;
   logic      error_in;

   logic      req_beat;
   logic      out_load;
   logic      range_bad;
   code_type  span;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] rounded;

   // register writes, out-of-range indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff   <= SHAPE_SINE;
         floor_ff   <= '0;
         ceiling_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVE_SHAPE:    shape_ff   <= csr_wdata[SHAPE_W-1:0];
            CSR_LEVEL_FLOOR:   floor_ff   <= csr_wdata[CODE_W-1:0];
            CSR_LEVEL_CEILING: ceiling_ff <= csr_wdata[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake: output register loads when empty or being drained,
   // no request is taken while reset is held
   assign out_load      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !reset && (!mid_valid_ff || out_load);
   assign req_beat      = req_if.valid && req_if.ready;

   // phase index steps after its sample is taken, if the advance flag is set
   always_comb begin
      phase_in = phase_ff;
      if (req_beat && req_if.advance) begin
         if (phase_ff == PHASE_W'(SAMPLES_PER_PERIOD - 1)) begin
            phase_in = '0;
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
         end
      end
   end

   // shape lookup for the current index
   wsg_level u_level (
      .shape (shape_ff),
      .phase (phase_ff),
      .level (level_in)
   );

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (req_if.ready) begin
         mid_valid_in = req_beat;
      end
   end

   // scaling: floor + round_half_up(level * span)
   assign range_bad = (floor_ff >= ceiling_ff);
   assign span      = ceiling_ff - floor_ff;
   assign product   = PROD_W'(level_ff) * PROD_W'(span);
   assign rounded   = product + PROD_W'(ROUND_HALF);

   always_comb begin
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      error_in     = error_ff;
      if (out_load) begin
         out_valid_in = mid_valid_ff;
         error_in     = range_bad;
         if (range_bad) begin
            code_in = floor_ff;
         end else begin
            code_in = floor_ff + rounded[LEVEL_FRAC_W +: CODE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         level_ff <= level_in;
      end
      code_ff  <= code_in;
      error_ff <= error_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.dac_code    = code_ff;
   assign rsp_if.range_error = error_ff;

endmodule

[hdl/wsg_checker.sv]
// port-level assertions for the waveform sample generator and their bind
module wsg_checker import wsg_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input code_type rsp_dac_code,
   input logic     rsp_range_error
);

   // beats taken in but not yet delivered
   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       in_beat;
   logic       out_beat;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (in_beat && !out_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!in_beat && out_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dac_code) && $stable(rsp_range_error))
      else $error("response payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without a request beat");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("request taken with both stages full");

endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_dac_code    (rsp_if.dac_code),
   .rsp_range_error (rsp_if.range_error)
);
